// File: rtl/bpc_pkg.sv
// Shared constants, types and divide-by-constant helpers for the blower PI command block.
package bpc_pkg;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_INTEGRAL_MIN = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INTEGRAL_MAX = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_OFF_COMMAND  = 2'd2;
  localparam int CFG_DATA_W = 32;

  // Reset values of the configuration registers
  localparam logic signed [31:0] INTEGRAL_MIN_RESET = 32'sd0;
  localparam logic [30:0]        INTEGRAL_MAX_RESET = 31'd30000;
  localparam logic [15:0]        OFF_COMMAND_RESET  = 16'd3000;

  // Measurement selection
  typedef enum logic [2:0] {
    MODE_SPEED           = 3'd0,
    MODE_PATIENT_PRESSURE = 3'd1,
    MODE_VALVE_PRESSURE  = 3'd2,
    MODE_INSP_FLOW       = 3'd3,
    MODE_EXH_FLOW        = 3'd4,
    MODE_MAINT_PRESSURE  = 3'd5
  } mode_t;

  localparam logic signed [15:0] LOW_PRESSURE_LIMIT  = 16'sd10;
  localparam logic signed [29:0] LOW_PRESSURE_OFFSET = 30'sd2600;

  // Reciprocals: floor(2^37/125) and floor(2^34/5)
  localparam int               DIV125_SHIFT = 37;
  localparam logic [30:0]      DIV125_RECIP = 31'd1099511627;
  localparam int               DIV5_SHIFT   = 34;
  localparam logic [31:0]      DIV5_RECIP   = 32'd3435973836;

  // Floor of n/125 from the reciprocal product; the estimate is at most one short
  function automatic logic [23:0] div125_fix(input logic [29:0] n,
                                             input logic [60:0] qprod);
    logic [23:0] q;
    logic [30:0] r;
    q = qprod[60:DIV125_SHIFT];
    r = {1'b0, n} - ({7'b0, q} * 31'd125);
    if (r >= 31'd125) begin
      q = q + 24'd1;
    end
    return q;
  endfunction

  // Floor of n/5 from the reciprocal product; the estimate is at most one short
  function automatic logic [28:0] div5_fix(input logic [30:0] n,
                                           input logic [62:0] qprod);
    logic [28:0] q;
    logic [31:0] r;
    q = qprod[62:DIV5_SHIFT];
    r = {1'b0, n} - ({3'b0, q} * 32'd5);
    if (r >= 32'd5) begin
      q = q + 29'd1;
    end
    return q;
  endfunction

endpackage

// File: rtl/blower_pi_command_core.sv
// Top level of the blower PI command block: nine-stage pipeline from measurements to command.
//
// One control tick is taken per transfer on the input channel and its result is loaded into
// the result register after passing through stage registers one to eight; a new tick can be
// taken in every cycle unless an output stall has backed up to the input, so the sustained
// rate is one item per clock. The depth is set by the two reciprocal multiply-and-correct
// divisions (by 1000 for the gain terms, by 10 for the command), each spread over two stages,
// with the integral accumulator updated in stage five. Stalls on the output hold the result
// register and back up stage by stage, so empty stages keep filling while a result waits. After
// a write to integral_max the full-scale value passes through the product register and then the
// full register. Register writes are taken at any time but must only be made while idle.
module blower_pi_command_core
  import bpc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  // configuration
  input  logic                    cfg_write_enable,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [15:0]             kp,
  input  logic [15:0]             ki,
  input  logic [15:0]             setpoint,
  input  logic [2:0]              mode,
  input  logic [15:0]             blower_speed,
  input  logic signed [15:0]      patient_pressure,
  input  logic signed [15:0]      valve_pressure,
  input  logic signed [15:0]      insp_flow,
  input  logic signed [15:0]      exh_flow,
  input  logic signed [15:0]      internal_pressure,
  input  logic                    vent_enabled,
  input  logic                    exh_overpressure,
  // output channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [15:0]             blower_command,
  output logic signed [31:0]      integral_value
);

  typedef struct packed {
    logic stop;
    logic low;
  } ctrl_t;

  // configuration registers
  logic signed [31:0] integral_min;
  logic [30:0]        integral_max;
  logic [15:0]        off_command;

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_min <= INTEGRAL_MIN_RESET;
      integral_max <= INTEGRAL_MAX_RESET;
      off_command  <= OFF_COMMAND_RESET;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        REG_INTEGRAL_MIN: integral_min <= $signed(cfg_data[31:0]);
        REG_INTEGRAL_MAX: integral_max <= cfg_data[30:0];
        REG_OFF_COMMAND:  off_command  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic [27:0]        full;
  logic signed [29:0] limit;

  bpc_full_scale u_full_scale (
    .clk          (clk),
    .integral_max (integral_max),
    .full         (full),
    .limit        (limit)
  );

  // stage valids and per-stage load enables
  logic [8:1] v;
  logic [9:1] rdy;

  always_comb begin
    rdy[9] = !out_valid || !out_stall;
    rdy[8] = !v[8] || rdy[9];
    rdy[7] = !v[7] || rdy[8];
    rdy[6] = !v[6] || rdy[7];
    rdy[5] = !v[5] || rdy[6];
    rdy[4] = !v[4] || rdy[5];
    rdy[3] = !v[3] || rdy[4];
    rdy[2] = !v[2] || rdy[3];
    rdy[1] = !v[1] || rdy[2];
  end

  assign in_stall = !rdy[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) begin
        v[1] <= in_valid;
      end
      for (int k = 2; k <= 8; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // stage 1: input register
  logic [15:0]        s1_kp, s1_ki, s1_setpoint, s1_blower_speed;
  logic [2:0]         s1_mode;
  logic signed [15:0] s1_patient_pressure, s1_valve_pressure, s1_insp_flow;
  logic signed [15:0] s1_exh_flow, s1_internal_pressure;
  logic               s1_vent_enabled, s1_exh_overpressure;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_kp                <= kp;
      s1_ki                <= ki;
      s1_setpoint          <= setpoint;
      s1_mode              <= mode;
      s1_blower_speed      <= blower_speed;
      s1_patient_pressure  <= patient_pressure;
      s1_valve_pressure    <= valve_pressure;
      s1_insp_flow         <= insp_flow;
      s1_exh_flow          <= exh_flow;
      s1_internal_pressure <= internal_pressure;
      s1_vent_enabled      <= vent_enabled;
      s1_exh_overpressure  <= exh_overpressure;
    end
  end

  // stage 2: error and gain products
  logic signed [17:0] sp_ext;
  logic signed [17:0] err;
  ctrl_t              s1_ctrl;

  assign sp_ext = $signed({2'b0, s1_setpoint});

  always_comb begin
    unique case (mode_t'(s1_mode))
      MODE_SPEED:            err = sp_ext - $signed({2'b0, s1_blower_speed});
      MODE_PATIENT_PRESSURE: err = sp_ext - $signed({{2{s1_patient_pressure[15]}},
                                                     s1_patient_pressure});
      MODE_VALVE_PRESSURE:   err = sp_ext - $signed({{2{s1_valve_pressure[15]}},
                                                     s1_valve_pressure});
      MODE_INSP_FLOW:        err = sp_ext - $signed({{2{s1_insp_flow[15]}}, s1_insp_flow});
      MODE_EXH_FLOW:         err = sp_ext - $signed({{2{s1_exh_flow[15]}}, s1_exh_flow});
      MODE_MAINT_PRESSURE:   err = sp_ext - $signed({{2{s1_internal_pressure[15]}},
                                                     s1_internal_pressure});
      default:               err = 18'sd0;
    endcase
  end

  assign s1_ctrl.stop = (s1_setpoint == 16'd0) || s1_exh_overpressure;
  assign s1_ctrl.low  = s1_vent_enabled && (s1_patient_pressure <= LOW_PRESSURE_LIMIT)
                        && (s1_mode != MODE_INSP_FLOW);

  logic signed [34:0] s2_prod_p, s2_prod_i;
  ctrl_t              s2_ctrl;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_prod_p <= $signed({1'b0, s1_kp}) * err;
      s2_prod_i <= $signed({1'b0, s1_ki}) * err;
      s2_ctrl   <= s1_ctrl;
    end
  end

  // stage 3: magnitude and reciprocal multiply for /1000 (as /8 then /125)
  logic [34:0] mag_p, mag_i;
  logic [29:0] s3_n_p, s3_n_i;
  logic [60:0] s3_q_p, s3_q_i;
  logic        s3_neg_p, s3_neg_i;
  ctrl_t       s3_ctrl;

  assign mag_p = s2_prod_p[34] ? 35'(-s2_prod_p) : 35'(s2_prod_p);
  assign mag_i = s2_prod_i[34] ? 35'(-s2_prod_i) : 35'(s2_prod_i);

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_n_p   <= mag_p[32:3];
      s3_n_i   <= mag_i[32:3];
      s3_q_p   <= mag_p[32:3] * DIV125_RECIP;
      s3_q_i   <= mag_i[32:3] * DIV125_RECIP;
      s3_neg_p <= s2_prod_p[34];
      s3_neg_i <= s2_prod_i[34];
      s3_ctrl  <= s2_ctrl;
    end
  end

  // stage 4: correct quotients and restore sign
  logic [23:0]        q_p, q_i;
  logic signed [24:0] s4_prop, s4_dint;
  ctrl_t              s4_ctrl;

  assign q_p = div125_fix(s3_n_p, s3_q_p);
  assign q_i = div125_fix(s3_n_i, s3_q_i);

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_prop <= s3_neg_p ? -$signed({1'b0, q_p}) : $signed({1'b0, q_p});
      s4_dint <= s3_neg_i ? -$signed({1'b0, q_i}) : $signed({1'b0, q_i});
      s4_ctrl <= s3_ctrl;
    end
  end

  // stage 5: integral accumulate and clamp (lower bound first, upper bound wins), zero on stop
  logic signed [31:0] integral;
  logic signed [32:0] isum, iclamp;
  logic signed [31:0] integral_next;

  always_comb begin
    isum = $signed({integral[31], integral}) + $signed({{8{s4_dint[24]}}, s4_dint});
    iclamp = isum;
    if (iclamp < $signed({integral_min[31], integral_min})) begin
      iclamp = $signed({integral_min[31], integral_min});
    end
    if (iclamp > $signed({2'b0, integral_max})) begin
      iclamp = $signed({2'b0, integral_max});
    end
    integral_next = s4_ctrl.stop ? 32'sd0 : iclamp[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral <= 32'sd0;
    end else if (rdy[5] && v[4]) begin
      integral <= integral_next;
    end
  end

  logic signed [24:0] s5_prop;
  logic signed [31:0] s5_int;
  ctrl_t              s5_ctrl;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s5_prop <= s4_prop;
      s5_int  <= integral_next;
      s5_ctrl <= s4_ctrl;
    end
  end

  // stage 6: command sum
  logic signed [32:0] s6_sum;
  logic signed [31:0] s6_int;
  ctrl_t              s6_ctrl;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s6_sum  <= $signed({{8{s5_prop[24]}}, s5_prop}) + $signed({s5_int[31], s5_int});
      s6_int  <= s5_int;
      s6_ctrl <= s5_ctrl;
    end
  end

  // stage 7: magnitude and reciprocal multiply for /10 (as /2 then /5)
  logic [32:0]        mag_c;
  logic [30:0]        s7_n;
  logic [62:0]        s7_q;
  logic               s7_neg;
  logic signed [31:0] s7_int;
  ctrl_t              s7_ctrl;

  assign mag_c = s6_sum[32] ? 33'(-s6_sum) : 33'(s6_sum);

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      s7_n    <= mag_c[31:1];
      s7_q    <= mag_c[31:1] * DIV5_RECIP;
      s7_neg  <= s6_sum[32];
      s7_int  <= s6_int;
      s7_ctrl <= s6_ctrl;
    end
  end

  // stage 8: corrected command
  logic [28:0]        q_c;
  logic signed [29:0] s8_cmd;
  logic signed [31:0] s8_int;
  ctrl_t              s8_ctrl;

  assign q_c = div5_fix(s7_n, s7_q);

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      s8_cmd  <= s7_neg ? -$signed({1'b0, q_c}) : $signed({1'b0, q_c});
      s8_int  <= s7_int;
      s8_ctrl <= s7_ctrl;
    end
  end

  // output stage: low-pressure limit, saturate, invert, or the off command on stop
  logic signed [29:0] full_s, c_lim, c_sat, c_inv;

  always_comb begin
    full_s = $signed({2'b0, full});
    c_lim  = (s8_ctrl.low && (s8_cmd >= limit)) ? limit : s8_cmd;
    c_sat  = c_lim;
    if (c_sat < 30'sd0) begin
      c_sat = 30'sd0;
    end
    if (c_sat > full_s) begin
      c_sat = full_s;
    end
    c_inv = full_s - c_sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy[9]) begin
      out_valid <= v[8];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      blower_command <= s8_ctrl.stop ? off_command : c_inv[15:0];
      integral_value <= s8_int;
    end
  end

endmodule

// File: rtl/bpc_full_scale.sv
// Full-scale command (integral_max / 10) and the low-pressure limit derived from it.
module bpc_full_scale
  import bpc_pkg::*;
(
  input  logic               clk,
  input  logic [30:0]        integral_max,
  output logic [27:0]        full,
  output logic signed [29:0] limit
);

  logic [30:0] n;
  logic [62:0] qprod;
  logic [28:0] q;

  // imax/10 == (imax >> 1) / 5
  always_ff @(posedge clk) begin
    n     <= {1'b0, integral_max[30:1]};
    qprod <= {1'b0, integral_max[30:1]} * DIV5_RECIP;
  end

  assign q = div5_fix(n, qprod);

  always_ff @(posedge clk) begin
    full  <= q[27:0];
    limit <= $signed({2'b0, q[27:0]}) - LOW_PRESSURE_OFFSET;
  end

endmodule

// File: rtl/bpc_checker.sv
// Port-level checks for the blower PI command block, bound to the top level.
module bpc_checker
  import bpc_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    cfg_write_enable,
  input logic [CFG_INDEX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0]   cfg_data,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [15:0]             blower_command,
  input logic signed [31:0]      integral_value
);

  // shadow of the clamp registers
  logic signed [31:0] mir_min;
  logic [30:0]        mir_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      mir_min <= INTEGRAL_MIN_RESET;
      mir_max <= INTEGRAL_MAX_RESET;
    end else if (cfg_write_enable) begin
      if (cfg_index == REG_INTEGRAL_MIN) begin
        mir_min <= $signed(cfg_data[31:0]);
      end
      if (cfg_index == REG_INTEGRAL_MAX) begin
        mir_max <= cfg_data[30:0];
      end
    end
  end

  // a result held under stall does not change
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(blower_command)
                               && $stable(integral_value))
    else $error("result changed while stalled");

  // with the result register empty nothing upstream can be blocked
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

  // a reported integral is zero (stop) or within its clamps; crossed clamps give the upper one
  a_integral_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (integral_value == 32'sd0)
      || ((integral_value <= $signed({1'b0, mir_max}))
          && ((integral_value >= mir_min) || (mir_min > $signed({1'b0, mir_max})))))
    else $error("integral outside its clamps");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind blower_pi_command_core bpc_checker u_bpc_checker (.*);
